FILE: design/cek_pkg.sv
// Shared types and constants for the complete elliptic integral K(k) pipeline.
package cek_pkg;

  localparam int LANDEN_STEPS_DEF = 8;
  localparam logic [31:0] PI_HALF_Q27 = 32'h0C90_FDAA;
  localparam int SQRT_STAGES = 31;
  localparam int DIV_STAGES = 30;
  localparam int STEP_LAT = 1 + SQRT_STAGES + DIV_STAGES + 2;

  typedef struct packed {
    logic valid;
    logic last;
    logic err;
  } side_t;

endpackage

FILE: design/cek_step.sv
// One pipelined descending Landen step: k -> k' = (k/(1+sqrt(1-k^2)))^2, P -> P*(1+k').
module cek_step (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic [29:0]         k_in,
  input  logic [31:0]         prod_in,
  input  cek_pkg::side_t      side_in,
  output logic [29:0]         k_out,
  output logic [31:0]         prod_out,
  output cek_pkg::side_t      side_out
);

  localparam int SN = cek_pkg::SQRT_STAGES;
  localparam int DN = cek_pkg::DIV_STAGES;

  typedef struct packed {
    logic [61:0]    v;
    logic [33:0]    rem;
    logic [30:0]    root;
    logic [29:0]    k;
    logic [31:0]    prod;
    cek_pkg::side_t side;
  } sq_t;

  typedef struct packed {
    logic [31:0]    d;
    logic [32:0]    rem;
    logic [29:0]    q;
    logic [31:0]    prod;
    cek_pkg::side_t side;
  } dv_t;

  // square k
  logic [59:0]    kk_r;
  logic [29:0]    ka_r;
  logic [31:0]    proda_r;
  cek_pkg::side_t sidea_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sidea_r <= '0;
    end else if (en) begin
      sidea_r <= side_in;
    end
    if (en) begin
      kk_r    <= k_in * k_in;
      ka_r    <= k_in;
      proda_r <= prod_in;
    end
  end

  // square root of 2^60 - k^2, two radicand bits per stage
  sq_t sq_r [1:SN];
  sq_t sq_in [0:SN-1];
  sq_t sq_nxt [0:SN-1];

  always_comb begin
    sq_in[0].v    = 62'h1000_0000_0000_0000 - {2'b00, kk_r};
    sq_in[0].rem  = '0;
    sq_in[0].root = '0;
    sq_in[0].k    = ka_r;
    sq_in[0].prod = proda_r;
    sq_in[0].side = sidea_r;
    for (int j = 1; j < SN; j++) begin
      sq_in[j] = sq_r[j];
    end
  end

  always_comb begin
    for (int j = 0; j < SN; j++) begin
      logic [33:0] rt;
      logic [33:0] trial;
      rt = {sq_in[j].rem[31:0], sq_in[j].v[61:60]};
      trial = {1'b0, sq_in[j].root, 2'b01};
      sq_nxt[j] = sq_in[j];
      sq_nxt[j].v = {sq_in[j].v[59:0], 2'b00};
      if (rt >= trial) begin
        sq_nxt[j].rem  = rt - trial;
        sq_nxt[j].root = {sq_in[j].root[29:0], 1'b1};
      end else begin
        sq_nxt[j].rem  = rt;
        sq_nxt[j].root = {sq_in[j].root[29:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < SN; j++) begin
      if (!rst_n) begin
        sq_r[j+1].side <= '0;
      end else if (en) begin
        sq_r[j+1].side <= sq_nxt[j].side;
      end
      if (en) begin
        sq_r[j+1].v    <= sq_nxt[j].v;
        sq_r[j+1].rem  <= sq_nxt[j].rem;
        sq_r[j+1].root <= sq_nxt[j].root;
        sq_r[j+1].k    <= sq_nxt[j].k;
        sq_r[j+1].prod <= sq_nxt[j].prod;
      end
    end
  end

  // restoring divide k*2^30 / (2^30 + s), one quotient bit per stage
  dv_t dv_r [1:DN];
  dv_t dv_in [0:DN-1];
  dv_t dv_nxt [0:DN-1];

  always_comb begin
    dv_in[0].d    = {1'b0, sq_r[SN].root} + 32'h4000_0000;
    dv_in[0].rem  = {3'b000, sq_r[SN].k};
    dv_in[0].q    = '0;
    dv_in[0].prod = sq_r[SN].prod;
    dv_in[0].side = sq_r[SN].side;
    for (int j = 1; j < DN; j++) begin
      dv_in[j] = dv_r[j];
    end
  end

  always_comb begin
    for (int j = 0; j < DN; j++) begin
      logic [32:0] r2;
      r2 = {dv_in[j].rem[31:0], 1'b0};
      dv_nxt[j] = dv_in[j];
      if (r2 >= {1'b0, dv_in[j].d}) begin
        dv_nxt[j].rem = r2 - {1'b0, dv_in[j].d};
        dv_nxt[j].q   = {dv_in[j].q[28:0], 1'b1};
      end else begin
        dv_nxt[j].rem = r2;
        dv_nxt[j].q   = {dv_in[j].q[28:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < DN; j++) begin
      if (!rst_n) begin
        dv_r[j+1].side <= '0;
      end else if (en) begin
        dv_r[j+1].side <= dv_nxt[j].side;
      end
      if (en) begin
        dv_r[j+1].d    <= dv_nxt[j].d;
        dv_r[j+1].rem  <= dv_nxt[j].rem;
        dv_r[j+1].q    <= dv_nxt[j].q;
        dv_r[j+1].prod <= dv_nxt[j].prod;
      end
    end
  end

  // new k = q^2 / 2^30
  logic [59:0]    qq;
  logic [29:0]    kn_r;
  logic [31:0]    prodb_r;
  cek_pkg::side_t sideb_r;

  assign qq = dv_r[DN].q * dv_r[DN].q;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sideb_r <= '0;
    end else if (en) begin
      sideb_r <= dv_r[DN].side;
    end
    if (en) begin
      kn_r    <= qq[59:30];
      prodb_r <= dv_r[DN].prod;
    end
  end

  // P * (1 + k), round half up, saturate
  logic [63:0]    pm;
  logic [33:0]    ps;
  logic [31:0]    prod_r;
  logic [29:0]    kout_r;
  cek_pkg::side_t sidec_r;

  assign pm = prodb_r * ({2'b00, kn_r} + 32'h4000_0000) + 64'h2000_0000;
  assign ps = pm[63:30];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sidec_r <= '0;
    end else if (en) begin
      sidec_r <= sideb_r;
    end
    if (en) begin
      prod_r <= (ps[33:32] != 2'b00) ? 32'hFFFF_FFFF : ps[31:0];
      kout_r <= kn_r;
    end
  end

  assign k_out    = kout_r;
  assign prod_out = prod_r;
  assign side_out = sidec_r;

endmodule

FILE: design/complete_elliptic_integral_k_core.sv
// Complete elliptic integral of the first kind K(k) by descending Landen steps,
// Q1.30 modulus in, Q5.27 result out. Fully pipelined: one modulus enters every
// cycle while the result side is not stalled; each step squares k in a register,
// then runs a digit-per-stage square root and a bit-per-stage divider, and ends
// with the registered closing multiplies. A stall on the result side while a
// result is held freezes the whole pipe. Moduli below 0 or at or above 1.0 return
// zero with range_error set; last passes through beside the data.
module complete_elliptic_integral_k_core #(
  parameter int LANDEN_STEPS = cek_pkg::LANDEN_STEPS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_modulus,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_integral,
  output logic        out_range_error,
  output logic        out_last_out
);

  logic en;
  logic out_valid_r;
  logic [31:0] integral_r;
  logic range_error_r;
  logic last_r;

  assign en = !out_valid_r || !out_stall;
  assign in_stall = !en;

  logic [29:0]    k_w    [0:LANDEN_STEPS];
  logic [31:0]    prod_w [0:LANDEN_STEPS];
  cek_pkg::side_t side_w [0:LANDEN_STEPS];

  logic in_err;
  assign in_err = in_modulus[31] | in_modulus[30];

  assign k_w[0]          = in_err ? 30'd0 : in_modulus[29:0];
  assign prod_w[0]       = cek_pkg::PI_HALF_Q27;
  assign side_w[0].valid = in_valid;
  assign side_w[0].last  = in_last;
  assign side_w[0].err   = in_err;

  for (genvar g = 0; g < LANDEN_STEPS; g++) begin : g_step
    cek_step u_step (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .k_in     (k_w[g]),
      .prod_in  (prod_w[g]),
      .side_in  (side_w[g]),
      .k_out    (k_w[g+1]),
      .prod_out (prod_w[g+1]),
      .side_out (side_w[g+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= side_w[LANDEN_STEPS].valid;
    end
    if (en) begin
      integral_r    <= side_w[LANDEN_STEPS].err ? 32'd0 : prod_w[LANDEN_STEPS];
      range_error_r <= side_w[LANDEN_STEPS].err;
      last_r        <= side_w[LANDEN_STEPS].last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_integral    = integral_r;
  assign out_range_error = range_error_r;
  assign out_last_out    = last_r;

`ifndef SYNTHESIS
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_range_error |-> out_integral == 32'd0)
    else $error("range error result not zero");
  a_stall_ties: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("input stall does not follow output backpressure");
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");
`endif

endmodule
